FILE: rtl/spal_pkg.sv
`default_nettype none

package spal_pkg;

    localparam int REQ_W      = 16;
    localparam int MAG_W      = REQ_W + 1;
    localparam int OFS_W      = REQ_W - 1;
    localparam int AVG_W      = 27;
    localparam int ALPHA_W    = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 27;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int GAIN_W     = 30;
    localparam int KIND_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT      = 1'b1;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KNEE   = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 25'd16777216;
    localparam logic [AVG_W-1:0]   LIMIT_RESET = 27'd134217727;
    localparam logic [AVG_W-1:0]   POWER_CEIL  = 27'd117440512;

    // first request on the boosted branch, 0.44 in Q1.15 rounded up
    localparam logic signed [REQ_W-1:0] KNEE_X = 16'sd14418;
    localparam logic [MUL_W-1:0]        SLOPE_Q28 = 32'd778462822;
    localparam logic [GAIN_W-1:0]       ONE_Q28   = 30'd268435456;
    // slope times the residue of the knee between KNEE_X and 0.44 in Q.32
    localparam logic [PROD_W-1:0]       KNEE_BIAS = 64'd778462822 * 64'd10486;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MAG_W-1:0]  mag;
        logic [OFS_W-1:0]  offset;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/spal_if.sv
`default_nettype none

interface spal_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [spal_pkg::REQ_W-1:0] current_request;

    modport source (output valid, output func, output current_request, input ready);
    modport sink (input valid, input func, input current_request, output ready);
endinterface

interface spal_out_if;
    logic                       valid;
    logic                       ready;
    logic [spal_pkg::AVG_W-1:0] filtered_power;
    logic                       over_limit;

    modport source (output valid, output filtered_power, output over_limit, input ready);
    modport sink (input valid, input filtered_power, input over_limit, output ready);
endinterface

`default_nettype wire

FILE: rtl/spal_front.sv
`default_nettype none

module spal_front (
    spal_in_if.sink          in_ch,
    input  wire logic        q_full,
    output spal_pkg::item_t  push_item,
    output logic             push
);

    logic [spal_pkg::MAG_W-1:0] x_ext;
    logic [spal_pkg::MAG_W-1:0] x_mag;
    logic                       knee;

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    assign x_ext = {in_ch.current_request[spal_pkg::REQ_W-1], in_ch.current_request};
    assign x_mag = in_ch.current_request[spal_pkg::REQ_W-1] ? (~x_ext + 1'b1) : x_ext;
    assign knee  = in_ch.current_request >= spal_pkg::KNEE_X;

    always_comb
    begin
        push_item.mag    = x_mag;
        push_item.offset = in_ch.current_request[spal_pkg::OFS_W-1:0]
                           - spal_pkg::KNEE_X[spal_pkg::OFS_W-1:0];
        if (in_ch.func)
        begin
            push_item.kind = spal_pkg::KIND_CLEAR;
        end
        else if (knee)
        begin
            push_item.kind = spal_pkg::KIND_KNEE;
        end
        else
        begin
            push_item.kind = spal_pkg::KIND_SQUARE;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spal_queue.sv
`default_nettype none

module spal_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire spal_pkg::item_t  push_item,
    input  wire logic             pop,
    output logic                  full,
    output logic                  not_empty,
    output spal_pkg::item_t       head
);

    spal_pkg::item_t entry_reg [0:1];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full      = count_reg[1];
    assign not_empty = count_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spal_back.sv
`default_nettype none

module spal_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire spal_pkg::item_t               q_item,
    output logic                               q_pop,
    input  wire logic [spal_pkg::ALPHA_W-1:0]  alpha,
    input  wire logic [spal_pkg::AVG_W-1:0]    limit,
    spal_out_if.source                         out_ch
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_SLOPE_MUL  = 4'd1;
    localparam logic [3:0] S_GAIN       = 4'd2;
    localparam logic [3:0] S_SCALE_MUL  = 4'd3;
    localparam logic [3:0] S_SCALE      = 4'd4;
    localparam logic [3:0] S_SQUARE_MUL = 4'd5;
    localparam logic [3:0] S_POWER      = 4'd6;
    localparam logic [3:0] S_STEP_MUL   = 4'd7;
    localparam logic [3:0] S_UPDATE     = 4'd8;

    localparam int AW = spal_pkg::AVG_W;
    localparam int MW = spal_pkg::MUL_W;

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;
    logic [spal_pkg::KIND_W-1:0]    kind_reg;
    logic [spal_pkg::KIND_W-1:0]    kind_next;
    logic [MW-1:0]                  mul_a_reg;
    logic [MW-1:0]                  mul_a_next;
    logic [MW-1:0]                  mul_b_reg;
    logic [MW-1:0]                  mul_b_next;
    logic [spal_pkg::PROD_W-1:0]    prod_reg;
    logic                           rise_reg;
    logic                           rise_next;
    logic [AW-1:0]                  avg_reg;
    logic [AW-1:0]                  avg_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [AW-1:0]                  out_power_reg;
    logic                           out_over_reg;

    logic [spal_pkg::PROD_W-1:0]    gain_sum;
    logic [spal_pkg::GAIN_W-1:0]    gain;
    logic [MW-1:0]                  m30;
    logic [AW-1:0]                  power;
    logic [AW-1:0]                  step;
    logic [AW-1:0]                  avg_new;
    logic                           slot_free;
    logic                           fire;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.filtered_power = out_power_reg;
    assign out_ch.over_limit     = out_over_reg;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign fire      = (state_reg == S_UPDATE) && slot_free;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        gain_sum = {prod_reg[spal_pkg::PROD_W-18:0], 17'b0} + spal_pkg::KNEE_BIAS;
        gain     = spal_pkg::ONE_Q28 + gain_sum[spal_pkg::PROD_W-3:32]
                   + {{(spal_pkg::GAIN_W-1){1'b0}}, gain_sum[31]};
        m30      = prod_reg[44:13] + {{(MW-1){1'b0}}, prod_reg[12]};
        if (kind_reg == spal_pkg::KIND_KNEE)
        begin
            power = prod_reg[62:36] + {{(AW-1){1'b0}}, prod_reg[35]};
        end
        else
        begin
            power = prod_reg[32:6] + {{(AW-1){1'b0}}, prod_reg[5]};
        end
        step = prod_reg[50:24] + {{(AW-1){1'b0}}, prod_reg[23]};
        if (kind_reg == spal_pkg::KIND_CLEAR)
        begin
            avg_new = '0;
        end
        else if (rise_reg)
        begin
            avg_new = avg_reg + step;
        end
        else
        begin
            avg_new = avg_reg - step;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        rise_next      = rise_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    kind_next = q_item.kind;
                    case (q_item.kind)
                        spal_pkg::KIND_KNEE:
                        begin
                            mul_a_next = spal_pkg::SLOPE_Q28;
                            mul_b_next = {{(MW-spal_pkg::OFS_W){1'b0}}, q_item.offset};
                            state_next = S_SLOPE_MUL;
                        end
                        spal_pkg::KIND_SQUARE:
                        begin
                            mul_a_next = {{(MW-spal_pkg::MAG_W){1'b0}}, q_item.mag};
                            mul_b_next = {{(MW-spal_pkg::MAG_W){1'b0}}, q_item.mag};
                            state_next = S_SQUARE_MUL;
                        end
                        default:
                        begin
                            state_next = S_UPDATE;
                        end
                    endcase
                end
            end
            S_SLOPE_MUL:
            begin
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                mul_a_next = {{(MW-spal_pkg::OFS_W){1'b0}}, mul_b_reg[spal_pkg::OFS_W-1:0]
                              + spal_pkg::KNEE_X[spal_pkg::OFS_W-1:0]};
                mul_b_next = {{(MW-spal_pkg::GAIN_W){1'b0}}, gain};
                state_next = S_SCALE_MUL;
            end
            S_SCALE_MUL:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                mul_a_next = m30;
                mul_b_next = m30;
                state_next = S_SQUARE_MUL;
            end
            S_SQUARE_MUL:
            begin
                state_next = S_POWER;
            end
            S_POWER:
            begin
                rise_next  = power >= avg_reg;
                mul_a_next = {{(MW-spal_pkg::ALPHA_W){1'b0}}, alpha};
                mul_b_next = {{(MW-AW){1'b0}}, (power >= avg_reg) ? (power - avg_reg)
                                                                    : (avg_reg - power)};
                state_next = S_STEP_MUL;
            end
            S_STEP_MUL:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (slot_free)
                begin
                    avg_next       = avg_new;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= spal_pkg::KIND_CLEAR;
            rise_reg      <= 1'b0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            rise_reg      <= rise_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg  <= mul_a_reg * mul_b_reg;
        if (fire)
        begin
            out_power_reg <= avg_new;
            out_over_reg  <= avg_new > limit;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/shaped_power_average_limiter_unit.sv
// Shaped power average limiter.
// in_ch carries one request per transfer: func (0 = sample, 1 = clear) and
// current_request, signed Q1.15. out_ch returns one result per request:
// filtered_power, the running average in unsigned Q3.24, and over_limit,
// set when that average is strictly above power_limit.
// Configuration: cfg_we with cfg_index 0 writes smoothing_weight (Q1.24,
// values above one act as one), index 1 writes power_limit. Write only while
// no request is in flight.
// A two-entry queue sits between the classifying front and the arithmetic
// back, so requests are taken while the back is busy or the output stalls.
// The back runs a sequencer around one shared 32x32 multiplier with a
// registered product, one request at a time: a clear goes straight to
// update, a sample runs square multiply, power, step multiply and update,
// at or above the knee after slope multiply, gain, scale multiply, scale.
// Reset clears the average, the queue and the output; weight resets to 0,
// limit to all ones. While out_ch is stalled the result holds, the back
// waits with the next result, and in_ch stops once the queue is full.
`default_nettype none

module shaped_power_average_limiter_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    spal_in_if.sink                                in_ch,
    spal_out_if.source                             out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [spal_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spal_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [spal_pkg::ALPHA_W-1:0] weight_reg;
    logic [spal_pkg::AVG_W-1:0]   limit_reg;
    logic [spal_pkg::ALPHA_W-1:0] alpha;

    spal_pkg::item_t push_item;
    spal_pkg::item_t head;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;

    assign alpha = (weight_reg > spal_pkg::ALPHA_ONE) ? spal_pkg::ALPHA_ONE : weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            limit_reg  <= spal_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spal_pkg::REG_SMOOTHING_WEIGHT:
                begin
                    weight_reg <= cfg_wdata[spal_pkg::ALPHA_W-1:0];
                end
                spal_pkg::REG_POWER_LIMIT:
                begin
                    limit_reg <= cfg_wdata[spal_pkg::AVG_W-1:0];
                end
                default:
                begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    spal_front u_front (
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push_item (push_item),
        .push      (push)
    );

    spal_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    spal_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (head),
        .q_pop   (pop),
        .alpha   (alpha),
        .limit   (limit_reg),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

FILE: rtl/spal_checker.sv
`default_nettype none

module spal_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [spal_pkg::AVG_W-1:0]  filtered_power,
    input  wire logic                        over_limit
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign pending_next = pending_reg + {2'b0, in_valid && in_ready}
                          - {2'b0, out_valid && out_ready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_power)
                                    && $stable(over_limit))
        else $error("result changed while stalled");

    a_over_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && over_limit |-> filtered_power != '0)
        else $error("over limit flagged with zero average");

    a_power_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> filtered_power <= spal_pkg::POWER_CEIL)
        else $error("average above largest shaped power");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a request in flight");

endmodule

bind shaped_power_average_limiter_unit spal_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .filtered_power (out_ch.filtered_power),
    .over_limit     (out_ch.over_limit)
);

`default_nettype wire
